// File: rtl/core/mbb_pkg.sv
// ----------------------------------------------------------------------------
// mbb_pkg: shared types and constants of the masked 3x3 box blur
// Row-slot store layout, controller states and the controller/datapath bus.
// ----------------------------------------------------------------------------
package mbb_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned ColW      = $clog2(MaxWidth);       // 10
  localparam int unsigned RowW      = $clog2(MaxHeight);      // 12
  localparam int unsigned WidthRegW = 11;
  localparam int unsigned HeightRegW = 13;
  localparam int unsigned CfgW      = 13;
  localparam int unsigned AddrW     = ColW + 2;               // slot, column
  localparam int unsigned WordW     = 25;
  localparam int unsigned SumW      = 12;                     // 9 * 255 < 4096
  localparam int unsigned LagW      = ColW + 2;

  localparam logic [0:0] CfgIdxWidth  = 1'b0;
  localparam logic [0:0] CfgIdxHeight = 1'b1;

  localparam logic FuncPixel = 1'b0;
  localparam logic FuncDrain = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StAcc,
    StDiv,
    StOut
  } state_e;

  typedef struct packed {
    logic             clr;       // clear sums
    logic             acc;       // add current tap to sums
    logic             div_start;
    logic             ld_pass;   // latch center word, passed through when blur is off
    logic             ld_out;    // load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_sts_t;

endpackage

// File: rtl/core/masked_box_blur_3x3_core.sv
// ----------------------------------------------------------------------------
// masked_box_blur_3x3_core: masked 3x3 box blur over a raster RGB stream
// Each result passes through the tap reads, the divide and the output
// load after the beat that causes it. Throughput: a beat per cycle when no
// result is due; while one is computed the input stalls, set by the single
// read port of the row-slot memory. A held result stalls the next load, and the input with it.
// Reset clears all counters; store contents are undefined until written.
// ----------------------------------------------------------------------------
module masked_box_blur_3x3_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [mbb_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      func_i,
  input  logic [7:0]                in_red_i,
  input  logic [7:0]                in_green_i,
  input  logic [7:0]                in_blue_i,
  input  logic                      blur_enable_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                out_red_o,
  output logic [7:0]                out_green_o,
  output logic [7:0]                out_blue_o,
  output logic                      frame_end_o
);

  logic                         wr_en;
  logic [mbb_pkg::AddrW-1:0]    wr_addr, rd_addr;
  logic [mbb_pkg::WordW-1:0]    wr_data;
  mbb_pkg::dp_cmd_t             cmd;
  mbb_pkg::dp_sts_t             sts;
  logic [3:0]                   den;

  mbb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .in_word_i   ({blur_enable_i, in_red_i, in_green_i, in_blue_i}),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .frame_end_o (frame_end_o),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_o   (rd_addr),
    .cmd_o       (cmd),
    .den_o       (den),
    .sts_i       (sts)
  );

  mbb_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .cmd_i     (cmd),
    .den_i     (den),
    .sts_o     (sts),
    .red_o     (out_red_o),
    .green_o   (out_green_o),
    .blue_o    (out_blue_o)
  );

endmodule

// File: rtl/core/mbb_divider.sv
// ----------------------------------------------------------------------------
// mbb_divider: reciprocal-multiply divide of the three channel sums
// Divisor is a tap count (1, 2, 3, 4, 6 or 9); operands, then quotients, are registered.
// ----------------------------------------------------------------------------
module mbb_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [3:0]                 den_i,
  input  logic [mbb_pkg::SumW-1:0]   num_r_i,
  input  logic [mbb_pkg::SumW-1:0]   num_g_i,
  input  logic [mbb_pkg::SumW-1:0]   num_b_i,
  output logic                       busy_o,
  output logic [7:0]                 q_r_o,
  output logic [7:0]                 q_g_o,
  output logic [7:0]                 q_b_o
);

  localparam int unsigned SumW   = mbb_pkg::SumW;
  localparam int unsigned RecipW = 17;
  localparam int unsigned Shift  = 16;
  localparam int unsigned ProdW  = SumW + RecipW;

  logic              busy_q;
  logic [3:0]        den_q;
  logic [SumW-1:0]   nr_q, ng_q, nb_q;
  logic [7:0]        qr_q, qg_q, qb_q;
  logic [RecipW-1:0] recip;
  logic [ProdW-1:0]  pr, pg, pb;

  // ceil(2^16 / n); exact truncation for every sum up to 9 * 255
  always_comb begin
    case (den_q)
      4'd1:    recip = 17'd65536;
      4'd2:    recip = 17'd32768;
      4'd3:    recip = 17'd21846;
      4'd4:    recip = 17'd16384;
      4'd6:    recip = 17'd10923;
      4'd9:    recip = 17'd7282;
      default: recip = '0;
    endcase
    pr = ProdW'(nr_q) * ProdW'(recip);
    pg = ProdW'(ng_q) * ProdW'(recip);
    pb = ProdW'(nb_q) * ProdW'(recip);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      nr_q <= num_r_i; ng_q <= num_g_i; nb_q <= num_b_i;
    end
    if (busy_q) begin
      qr_q <= pr[Shift+7:Shift];
      qg_q <= pg[Shift+7:Shift];
      qb_q <= pb[Shift+7:Shift];
    end
  end

  assign busy_o = busy_q;
  assign q_r_o  = qr_q;
  assign q_g_o  = qg_q;
  assign q_b_o  = qb_q;

endmodule

// File: rtl/core/mbb_datapath.sv
// ----------------------------------------------------------------------------
// mbb_datapath: row-slot store, tap accumulation and result register
// Four row slots in one memory; neighbors are read one at a time.
// ----------------------------------------------------------------------------
module mbb_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [mbb_pkg::AddrW-1:0]     wr_addr_i,
  input  logic [mbb_pkg::WordW-1:0]     wr_data_i,
  input  logic [mbb_pkg::AddrW-1:0]     rd_addr_i,
  input  mbb_pkg::dp_cmd_t              cmd_i,
  input  logic [3:0]                    den_i,
  output mbb_pkg::dp_sts_t              sts_o,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o
);

  localparam int unsigned Depth = 4 * mbb_pkg::MaxWidth;

  logic [mbb_pkg::WordW-1:0] mem [Depth];
  logic [mbb_pkg::WordW-1:0] rd_q;
  logic [mbb_pkg::WordW-1:0] center_q;
  logic [mbb_pkg::SumW-1:0]  sr_q, sg_q, sb_q;
  logic [7:0]                qr, qg, qb;
  logic [7:0]                red_q, green_q, blue_q;
  logic                      busy;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    rd_q <= mem[rd_addr_i];
  end

  // first read after clr is the center tap
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      sr_q <= '0; sg_q <= '0; sb_q <= '0;
    end else if (cmd_i.acc) begin
      sr_q <= sr_q + mbb_pkg::SumW'(rd_q[23:16]);
      sg_q <= sg_q + mbb_pkg::SumW'(rd_q[15:8]);
      sb_q <= sb_q + mbb_pkg::SumW'(rd_q[7:0]);
    end
    if (cmd_i.ld_pass) center_q <= rd_q;
  end

  mbb_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .den_i   (den_i),
    .num_r_i (sr_q),
    .num_g_i (sg_q),
    .num_b_i (sb_q),
    .busy_o  (busy),
    .q_r_o   (qr),
    .q_g_o   (qg),
    .q_b_o   (qb)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_out) begin
      red_q   <= center_q[24] ? qr : center_q[23:16];
      green_q <= center_q[24] ? qg : center_q[15:8];
      blue_q  <= center_q[24] ? qb : center_q[7:0];
    end
  end

  assign sts_o.div_busy = busy;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

// File: rtl/core/mbb_ctrl.sv
// ----------------------------------------------------------------------------
// mbb_ctrl: frame counters, lag tracking and per-result tap sequencer
// Walks the center and all nine taps of the 3x3 window in turn, adding the in-bounds ones.
// ----------------------------------------------------------------------------
module mbb_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_idx_i,
  input  logic [mbb_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic [mbb_pkg::WordW-1:0]         in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              frame_end_o,
  output logic                              wr_en_o,
  output logic [mbb_pkg::AddrW-1:0]         wr_addr_o,
  output logic [mbb_pkg::WordW-1:0]         wr_data_o,
  output logic [mbb_pkg::AddrW-1:0]         rd_addr_o,
  output mbb_pkg::dp_cmd_t                  cmd_o,
  output logic [3:0]                        den_o,
  input  mbb_pkg::dp_sts_t                  sts_i
);

  localparam int unsigned ColW = mbb_pkg::ColW;
  localparam int unsigned RowW = mbb_pkg::RowW;
  localparam int unsigned LagW = mbb_pkg::LagW;

  mbb_pkg::state_e state_q, state_d;

  logic [mbb_pkg::WidthRegW-1:0]  wreg_q;
  logic [mbb_pkg::HeightRegW-1:0] hreg_q;
  logic [ColW:0] w_eff;    // 1..1024
  logic [RowW:0] h_eff;    // 1..4096
  logic [ColW-1:0] icol_q, icol_d, ocol_q, ocol_d;
  logic [RowW-1:0] irow_q, irow_d, orow_q, orow_d;
  logic [LagW-1:0] lag_q, lag_d;
  logic            done_q, done_d;
  logic [3:0]      tap_q, tap_d;   // 0 = center, then 1..9 raster taps
  logic [3:0]      cnt_q, cnt_d;
  logic            fe_q, fe_d;
  logic            out_vld_q, out_vld_d;
  logic            fe_out_q, fe_out_d;

  always_comb begin
    w_eff = (wreg_q == '0) ? (ColW+1)'(1)
          : (wreg_q > mbb_pkg::WidthRegW'(mbb_pkg::MaxWidth))
            ? (ColW+1)'(mbb_pkg::MaxWidth) : wreg_q[ColW:0];
    h_eff = (hreg_q == '0) ? (RowW+1)'(1)
          : (hreg_q > mbb_pkg::HeightRegW'(mbb_pkg::MaxHeight))
            ? (RowW+1)'(mbb_pkg::MaxHeight) : hreg_q[RowW:0];
  end

  // tap geometry
  logic signed [ColW+1:0] tc;
  logic signed [RowW+1:0] tr;
  logic                   tap_ok;
  logic [1:0]             dr, dc;
  always_comb begin
    dr = 2'd1; dc = 2'd1;
    case (tap_q)
      4'd1: begin dr = 2'd0; dc = 2'd0; end
      4'd2: begin dr = 2'd0; dc = 2'd1; end
      4'd3: begin dr = 2'd0; dc = 2'd2; end
      4'd4: begin dr = 2'd1; dc = 2'd0; end
      4'd6: begin dr = 2'd1; dc = 2'd2; end
      4'd7: begin dr = 2'd2; dc = 2'd0; end
      4'd8: begin dr = 2'd2; dc = 2'd1; end
      4'd9: begin dr = 2'd2; dc = 2'd2; end
      default: begin end   // center
    endcase
    tr = (RowW+2)'(orow_q) + (RowW+2)'(dr) - (RowW+2)'(1);
    tc = (ColW+2)'(ocol_q) + (ColW+2)'(dc) - (ColW+2)'(1);
    tap_ok = (tr >= 0) && (tc >= 0) &&
             (tr < $signed({1'b0, h_eff})) && (tc < $signed({1'b0, w_eff}));
    rd_addr_o = {tr[1:0], tc[ColW-1:0]};
  end

  logic in_acc, out_acc, pix, drain_go, emit_pix;
  assign out_valid_o = out_vld_q;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign pix      = in_acc && func_i == mbb_pkg::FuncPixel && !done_q;
  assign drain_go = in_acc && func_i == mbb_pkg::FuncDrain && done_q && lag_q != '0;
  assign emit_pix = pix && ({1'b0, lag_q} + 1'b1 > (LagW+1)'(w_eff) + 1'b1);

  assign wr_en_o   = pix;
  assign wr_addr_o = {irow_q[1:0], icol_q};
  assign wr_data_o = in_word_i;
  assign den_o     = cnt_q;
  assign frame_end_o = fe_out_q;

  always_comb begin
    state_d = state_q;
    icol_d = icol_q; irow_d = irow_q; ocol_d = ocol_q; orow_d = orow_q;
    lag_d = lag_q; done_d = done_q; tap_d = tap_q; cnt_d = cnt_q; fe_d = fe_q;
    out_vld_d = out_vld_q; fe_out_d = fe_out_q;
    if (out_acc) out_vld_d = 1'b0;
    cmd_o = '0;
    in_stall_o  = (state_q != mbb_pkg::StIdle);
    case (state_q)
      mbb_pkg::StIdle: begin
        if (pix) begin
          lag_d = lag_q + 1'b1;
          if (32'(icol_q) + 1 >= 32'(w_eff)) begin
            icol_d = '0;
            if (32'(irow_q) + 1 >= 32'(h_eff)) begin
              irow_d = '0; done_d = 1'b1;
            end else irow_d = irow_q + 1'b1;
          end else icol_d = icol_q + 1'b1;
        end
        if (emit_pix || drain_go) begin
          state_d = mbb_pkg::StRead;
          tap_d = 4'd0;
          cnt_d = '0;
          cmd_o.clr = 1'b1;
        end
      end
      mbb_pkg::StRead: begin
        // read issued for tap_q; data is valid next cycle
        state_d = mbb_pkg::StAcc;
      end
      mbb_pkg::StAcc: begin
        if (tap_q == 4'd0) cmd_o.ld_pass = 1'b1;
        else if (tap_ok) begin
          cmd_o.acc = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
        if (tap_q == 4'd9) begin
          state_d = mbb_pkg::StDiv;
        end else begin
          tap_d = tap_q + 1'b1;
          state_d = mbb_pkg::StRead;
        end
      end
      mbb_pkg::StDiv: begin
        // cnt_q final on entry; start once, then wait
        if (tap_q == 4'd9) begin
          cmd_o.div_start = 1'b1;
          tap_d = 4'd10;
        end else if (!sts_i.div_busy) begin
          state_d = mbb_pkg::StOut;
          if (lag_q != '0) lag_d = lag_q - 1'b1;
          fe_d = 1'b0;
          if (32'(ocol_q) + 1 >= 32'(w_eff)) begin
            ocol_d = '0;
            if (32'(orow_q) + 1 >= 32'(h_eff)) begin
              fe_d = 1'b1;
              orow_d = '0; icol_d = '0; irow_d = '0; lag_d = '0; done_d = 1'b0;
            end else orow_d = orow_q + 1'b1;
          end else ocol_d = ocol_q + 1'b1;
        end
      end
      mbb_pkg::StOut: begin
        // load once the output register is free or leaving this cycle
        if (!out_vld_q || out_acc) begin
          cmd_o.ld_out = 1'b1;
          out_vld_d = 1'b1;
          fe_out_d = fe_q;
          state_d = mbb_pkg::StIdle;
        end
      end
      default: state_d = mbb_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbb_pkg::StIdle;
      wreg_q <= mbb_pkg::WidthRegW'(mbb_pkg::MaxWidth);
      hreg_q <= mbb_pkg::HeightRegW'(1);
      icol_q <= '0; irow_q <= '0; ocol_q <= '0; orow_q <= '0;
      lag_q <= '0; done_q <= 1'b0; tap_q <= '0; cnt_q <= '0; fe_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == mbb_pkg::CfgIdxWidth) wreg_q <= cfg_data_i[mbb_pkg::WidthRegW-1:0];
      else                                   hreg_q <= cfg_data_i;
      state_q <= mbb_pkg::StIdle;
      icol_q <= '0; irow_q <= '0; ocol_q <= '0; orow_q <= '0;
      lag_q <= '0; done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      icol_q <= icol_d; irow_q <= irow_d; ocol_q <= ocol_d; orow_q <= orow_d;
      lag_q <= lag_d; done_q <= done_d; tap_q <= tap_d; cnt_q <= cnt_d; fe_q <= fe_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      fe_out_q  <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      fe_out_q  <= fe_out_d;
    end
  end

  // lag reaches width+2 while the result that brings it back is computed
  a_lag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(lag_q) <= 32'(w_eff) + 2) else $error("lag beyond width+2");
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != mbb_pkg::StIdle |-> !wr_en_o) else $error("store write while busy");
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mbb_pkg::StOut |-> cnt_q >= 4'd1 && cnt_q <= 4'd9)
    else $error("bad tap count");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result beat dropped");

endmodule

// File: sim/tb_masked_box_blur_3x3_core.sv
// ----------------------------------------------------------------------------
// tb_masked_box_blur_3x3_core: self-checking bench for the masked 3x3 blur
// Drives raster frames and drain beats, predicts every result pixel with a
// local model of the row slots and lag, and checks results in order under
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_masked_box_blur_3x3_core;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned SettleCyc = 60;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       fend;
  } pixel_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [0:0]                 cfg_idx = mbb_pkg::CfgIdxWidth;
  logic [mbb_pkg::CfgW-1:0]   cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       func = mbb_pkg::FuncPixel;
  logic [7:0]                 in_red = '0, in_green = '0, in_blue = '0;
  logic                       blur_en = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [7:0]                 out_red, out_green, out_blue;
  logic                       frame_end;

  masked_box_blur_3x3_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .func_i(func),
    .in_red_i(in_red), .in_green_i(in_green), .in_blue_i(in_blue),
    .blur_enable_i(blur_en),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_red_o(out_red), .out_green_o(out_green), .out_blue_o(out_blue),
    .frame_end_o(frame_end)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------- predictor state ----------------
  logic [mbb_pkg::WordW-1:0] row_slots [0:4*mbb_pkg::MaxWidth-1];
  int unsigned width_reg = 1024, height_reg = 1;
  int unsigned icol, irow, ocol, orow, pending;
  bit          in_done;
  pixel_t      expected_q[$];
  int          errors = 0;
  int          sent = 0;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;

  function automatic int unsigned eff_w();
    return (width_reg < 1) ? 1
         : (width_reg > mbb_pkg::MaxWidth) ? mbb_pkg::MaxWidth : width_reg;
  endfunction

  function automatic int unsigned eff_h();
    return (height_reg < 1) ? 1
         : (height_reg > mbb_pkg::MaxHeight) ? mbb_pkg::MaxHeight : height_reg;
  endfunction

  function automatic int unsigned slot_addr(int unsigned row, int unsigned col);
    return (row % 4) * mbb_pkg::MaxWidth + (col % mbb_pkg::MaxWidth);
  endfunction

  function automatic void restart_frame();
    icol = 0; irow = 0; ocol = 0; orow = 0; pending = 0; in_done = 0;
  endfunction

  function automatic void blur_next();
    int unsigned w, h, n, sr, sg, sb;
    int r, c;
    logic [mbb_pkg::WordW-1:0] ctr, v;
    pixel_t p;
    w = eff_w(); h = eff_h();
    n = 0; sr = 0; sg = 0; sb = 0;
    ctr = row_slots[slot_addr(orow, ocol)];
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        r = int'(orow) + dr;
        c = int'(ocol) + dc;
        if (r >= 0 && c >= 0 && r < int'(h) && c < int'(w)) begin
          v = row_slots[slot_addr(r, c)];
          sr += 32'(v[23:16]); sg += 32'(v[15:8]); sb += 32'(v[7:0]);
          n++;
        end
      end
    end
    if (ctr[24]) begin
      p.red = 8'(sr / n); p.green = 8'(sg / n); p.blue = 8'(sb / n);
    end else begin
      p.red = ctr[23:16]; p.green = ctr[15:8]; p.blue = ctr[7:0];
    end
    p.fend = 1'b0;
    if (pending > 0) pending--;
    ocol++;
    if (ocol >= w) begin
      ocol = 0;
      orow++;
      if (orow >= h) begin
        p.fend = 1'b1;
        restart_frame();
      end
    end
    expected_q.push_back(p);
  endfunction

  function automatic void predict_beat(logic f, logic [7:0] r, logic [7:0] g,
                                       logic [7:0] b, logic en);
    int unsigned w, h;
    w = eff_w(); h = eff_h();
    if (f == mbb_pkg::FuncDrain) begin
      if (in_done && pending != 0) blur_next();
      return;
    end
    if (in_done) return;
    row_slots[slot_addr(irow, icol)] = {en, r, g, b};
    pending++;
    icol++;
    if (icol >= w) begin
      icol = 0;
      irow++;
      if (irow >= h) begin
        irow = 0;
        in_done = 1;
      end
    end
    if (pending > w + 1) blur_next();
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    pixel_t exp_p;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result exp none got rgb=%h %h %h fe=%b", $time,
                 out_red, out_green, out_blue, frame_end);
        errors++;
      end else begin
        exp_p = expected_q.pop_front();
        if (exp_p.red !== out_red)
          begin $display("%0t: red exp %h got %h", $time, exp_p.red, out_red); errors++; end
        if (exp_p.green !== out_green)
          begin $display("%0t: green exp %h got %h", $time, exp_p.green, out_green); errors++; end
        if (exp_p.blue !== out_blue)
          begin $display("%0t: blue exp %h got %h", $time, exp_p.blue, out_blue); errors++; end
        if (exp_p.fend !== frame_end)
          begin $display("%0t: frame_end exp %b got %b", $time, exp_p.fend, frame_end); errors++; end
      end
    end
  end

  // receiver: random stalls, or a counted long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no beat on either side
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic send_beat(logic f, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic en);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f; in_red <= r; in_green <= g; in_blue <= b; blur_en <= en;
    do @(posedge clk); while (in_stall);
    predict_beat(f, r, g, b, en);
    sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    release_input();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [mbb_pkg::CfgW-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    if (idx == mbb_pkg::CfgIdxWidth) width_reg = 32'(val[mbb_pkg::WidthRegW-1:0]);
    else height_reg = 32'(val[mbb_pkg::HeightRegW-1:0]);
    restart_frame();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    write_reg(mbb_pkg::CfgIdxWidth, mbb_pkg::CfgW'(w));
    write_reg(mbb_pkg::CfgIdxHeight, mbb_pkg::CfgW'(h));
  endtask

  task automatic send_pixel(int unsigned en_pct);
    send_beat(mbb_pkg::FuncPixel, 8'($urandom), 8'($urandom), 8'($urandom),
              $urandom_range(99) < en_pct);
  endtask

  task automatic send_drain();
    send_beat(mbb_pkg::FuncDrain, 8'($urandom), 8'($urandom), 8'($urandom),
              1'($urandom));
  endtask

  // one well-formed frame followed by enough drain beats
  task automatic send_frame(int unsigned en_pct);
    for (int unsigned i = 0; i < eff_w() * eff_h(); i++) send_pixel(en_pct);
    for (int unsigned i = 0; i <= eff_w(); i++) send_drain();
  endtask

  // ---------------- tests ----------------
  task automatic test_field_extremes();
    set_size(3, 3);
    for (int i = 0; i < 9; i++) begin
      if (i % 2 == 0) send_beat(mbb_pkg::FuncPixel, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      else send_beat(mbb_pkg::FuncPixel, 8'h00, 8'h00, 8'h00, i == 3);
    end
    for (int i = 0; i < 4; i++) send_beat(mbb_pkg::FuncDrain, 8'hFF, 8'h00, 8'hFF, 1'b1);
  endtask

  task automatic test_stray_beats();
    set_size(2, 2);
    send_pixel(50);
    send_beat(mbb_pkg::FuncDrain, 8'h00, 8'h00, 8'h00, 1'b0); // before frame end: ignored
    send_pixel(50); send_pixel(50); send_pixel(50);
    send_pixel(50);                           // pixel after frame end: ignored
    for (int i = 0; i < 4; i++) send_beat(mbb_pkg::FuncDrain, 8'h00, 8'h00, 8'h00, 1'b1);
  endtask

  task automatic test_degenerate_sizes();
    set_size(0, 0);                           // both clamp to one
    send_frame(100);
    set_size(1, 5);
    send_frame(70);
    set_size(6, 1);
    send_frame(70);
  endtask

  task automatic test_clamped_sizes();
    set_size(1, 8191);                        // height clamps; cut short by rewrite
    repeat (5) send_pixel(50);
    set_size(2047, 1);                        // width clamps; no result this early
    repeat (5) send_pixel(50);
  endtask

  task automatic test_random_frames(int unsigned budget);
    int unsigned stop;
    stop = sent + budget;
    while (sent < stop) begin
      if ($urandom_range(9) == 0) set_size($urandom_range(1, 3), $urandom_range(1, 4));
      else set_size($urandom_range(2, 12), $urandom_range(1, 6));
      if ($urandom_range(4) == 0) begin
        // broken frame: partial pixels plus noise, then restart by config
        repeat ($urandom_range(1, 10))
          send_beat(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    1'($urandom));
      end else begin
        send_frame($urandom_range(100));
      end
    end
  endtask

  task automatic test_backpressure();
    set_size(4, 4);
    hold_cycles = 400;
    send_frame(60);
    wait_drained();
  endtask

  task automatic test_pause_midframe();
    set_size(5, 3);
    repeat (9) send_pixel(60);
    wait_drained();                           // sender waits for every result
    repeat (6) send_pixel(60);
    repeat (6) send_beat(mbb_pkg::FuncDrain, 8'h00, 8'h00, 8'h00, 1'b0);
  endtask

  initial begin
    restart_frame();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_stray_beats();
    test_degenerate_sizes();
    test_clamped_sizes();
    test_backpressure();
    test_pause_midframe();

    sender_idle_pct = 0;  recv_stall_pct = 0;  test_random_frames(80);
    sender_idle_pct = 67; recv_stall_pct = 0;  test_random_frames(80);
    sender_idle_pct = 0;  recv_stall_pct = 67; test_random_frames(80);
    sender_idle_pct = 37; recv_stall_pct = 37; test_random_frames(80);

    wait_drained();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
